>>> sv/ibte_pkg.sv
// ibte_pkg: types, character codes and constants shared by the time string
// to epoch converter. No dependencies.
package ibte_pkg;

  // input and output transactions
  typedef struct packed {
    logic       first;
    logic [7:0] char_code;
  } ibte_in_t;

  typedef struct packed {
    logic        ok;
    logic [37:0] seconds;
  } ibte_out_t;

  // one parsed string handed from the front to the back
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } ibte_job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SPLIT,
    B_DAYS,
    B_MUL,
    B_EMIT
  } ibte_back_state_e;

  localparam int unsigned QDEPTH = 2;

  // position counter
  localparam logic [4:0] POS_IDLE  = 5'd16;
  localparam logic [4:0] POS_T     = 5'd8;
  localparam logic [4:0] POS_DELIM = 5'd15;
  localparam logic [4:0] POS_MONTH = 5'd4;
  localparam logic [4:0] POS_DAY   = 5'd6;
  localparam logic [4:0] POS_HOUR  = 5'd9;
  localparam logic [4:0] POS_MIN   = 5'd11;
  localparam logic [4:0] POS_SEC   = 5'd13;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_T     = 8'd84;

  // range limits
  localparam logic [13:0] EPOCH_YEAR = 14'd1970;
  localparam logic [6:0]  MAX_MONTH  = 7'd12;
  localparam logic [6:0]  MAX_DAY    = 7'd31;
  localparam logic [6:0]  MAX_HOUR   = 7'd23;
  localparam logic [6:0]  MAX_MINUTE = 7'd59;
  localparam logic [6:0]  MAX_SECOND = 7'd61;

  // x / 25 = (x * RECIP25) >> 16, exact for x below 4096
  localparam logic [11:0] RECIP25     = 12'd2622;
  // days from 0000-03-01 to 1970-01-01, plus one for the day-of-month base
  localparam logic [23:0] EPOCH_DAYS1 = 24'd719469;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;
  localparam logic [11:0] SEC_PER_HR  = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

  // days from march 1 to the first of the shifted month (march = 0)
  function automatic logic [8:0] doy_of(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/iso_basic_time_to_epoch.sv
// iso_basic_time_to_epoch: top level, parser front, job queue and epoch back.
// Depends on ibte_pkg, ibte_front, ibte_fifo, ibte_back.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o  ibte_in_t  (first, char_code)
//   out      source     out_valid_o/out_stall_i ibte_out_t (ok, seconds)
//
// one character is taken per cycle while the job queue has room.
// each finished string passes the back through the steps pop, split, days,
// multiply and emit, set by its 24x17 day multiplier and adder steps.
// a result waits in the output register while further characters are taken.
// reset idles the parser until a character with first set, empties the queue.
module iso_basic_time_to_epoch import ibte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  ibte_in_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ibte_out_t out_data_o
);

  logic      push, full, pop, empty;
  ibte_job_t job_in, job_out;

  ibte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  ibte_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_out)
  );

  ibte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/ibte_front.sv
// ibte_front: per-character parser with position counter and decimal
// accumulators; pushes one job per string. Depends on ibte_pkg.
module ibte_front import ibte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  ibte_in_t  in_data_i,
  output logic      in_stall_o,
  input  logic      full_i,
  output logic      push_o,
  output ibte_job_t job_o
);

  logic [4:0]  pos_q, pos_d, pos_e;
  logic [13:0] year_q, year_d, year_e;
  logic [6:0]  month_q, month_d, month_e;
  logic [6:0]  day_q, day_d, day_e;
  logic [6:0]  hour_q, hour_d, hour_e;
  logic [6:0]  minute_q, minute_d, minute_e;
  logic [6:0]  second_q, second_d, second_e;
  logic        accept;
  logic [7:0]  c;
  logic [3:0]  dig;
  logic        is_digit;
  logic        is_delim;
  logic        in_range;

  function automatic logic [13:0] app14(input logic [13:0] a, input logic [3:0] d);
    return {a[10:0], 3'b000} + {a[12:0], 1'b0} + {10'd0, d};
  endfunction

  function automatic logic [6:0] app7(input logic [6:0] a, input logic [3:0] d);
    return {a[3:0], 3'b000} + {a[5:0], 1'b0} + {3'd0, d};
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign c          = in_data_i.char_code;
  assign dig        = c[3:0];
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_delim   = (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) ||
                      (c == CH_COLON) || (c == CH_COMMA);

  // first restarts the string and clears the fields
  assign pos_e    = in_data_i.first ? 5'd0  : pos_q;
  assign year_e   = in_data_i.first ? 14'd0 : year_q;
  assign month_e  = in_data_i.first ? 7'd0  : month_q;
  assign day_e    = in_data_i.first ? 7'd0  : day_q;
  assign hour_e   = in_data_i.first ? 7'd0  : hour_q;
  assign minute_e = in_data_i.first ? 7'd0  : minute_q;
  assign second_e = in_data_i.first ? 7'd0  : second_q;

  assign in_range = (year_e >= EPOCH_YEAR) && (month_e != 7'd0) && (month_e <= MAX_MONTH) &&
                    (day_e != 7'd0) && (day_e <= MAX_DAY) && (hour_e <= MAX_HOUR) &&
                    (minute_e <= MAX_MINUTE) && (second_e <= MAX_SECOND);

  always_comb begin
    pos_d        = pos_q;
    year_d       = year_q;
    month_d      = month_q;
    day_d        = day_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    second_d     = second_q;
    push_o       = 1'b0;
    job_o.ok     = 1'b0;
    job_o.year   = year_e;
    job_o.month  = month_e;
    job_o.day    = day_e;
    job_o.hour   = hour_e;
    job_o.minute = minute_e;
    job_o.second = second_e;
    if (accept) begin
      pos_d    = pos_e;
      year_d   = year_e;
      month_d  = month_e;
      day_d    = day_e;
      hour_d   = hour_e;
      minute_d = minute_e;
      second_d = second_e;
      if (!pos_e[4]) begin
        if (pos_e == POS_T) begin
          if (c == CH_T) begin
            pos_d = pos_e + 5'd1;
          end else begin
            push_o = 1'b1;
            pos_d  = POS_IDLE;
          end
        end else if (pos_e == POS_DELIM) begin
          push_o   = 1'b1;
          job_o.ok = is_delim && in_range;
          pos_d    = POS_IDLE;
        end else if (!is_digit) begin
          push_o = 1'b1;
          pos_d  = POS_IDLE;
        end else begin
          pos_d = pos_e + 5'd1;
          if (pos_e < POS_MONTH) begin
            year_d = app14(year_e, dig);
          end else if (pos_e < POS_DAY) begin
            month_d = app7(month_e, dig);
          end else if (pos_e < POS_T) begin
            day_d = app7(day_e, dig);
          end else if (pos_e < POS_MIN) begin
            hour_d = app7(hour_e, dig);
          end else if (pos_e < POS_SEC) begin
            minute_d = app7(minute_e, dig);
          end else begin
            second_d = app7(second_e, dig);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_IDLE;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
    end else begin
      pos_q    <= pos_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
    end
  end

  // a string ends in exactly one job and leaves the parser idle
  a_push_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> pos_q == POS_IDLE)
    else $error("parser not idle after job push");

endmodule

>>> sv/ibte_fifo.sv
// ibte_fifo: short job queue between parser and epoch arithmetic.
// Depends on ibte_pkg.
module ibte_fifo import ibte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ibte_job_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output ibte_job_t data_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  ibte_job_t         mem_q [QDEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i  ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("job queue overflow or underflow");

endmodule

>>> sv/ibte_back.sv
// ibte_back: epoch arithmetic sequencer, one job in five steps, with the
// output register. Depends on ibte_pkg.
module ibte_back import ibte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  ibte_job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ibte_out_t out_data_o
);

  ibte_back_state_e state_q, state_d;
  ibte_job_t        job_q;
  logic [13:0]      ya;
  logic [3:0]       mp;
  logic [23:0]      p100, p400;
  logic [13:0]      ya_q;
  logic [8:0]       doy_q;
  logic [7:0]       q100_q, q400_q;
  logic [21:0]      y365_q;
  logic [18:0]      hsec_q;
  logic [12:0]      msec_q;
  logic [23:0]      days_q;
  logic [19:0]      hms_q;
  logic [40:0]      prod_q;
  logic             load_out;
  logic             out_vld_q;
  ibte_out_t        out_q;

  // march-based year and month
  assign ya   = (job_q.month <= 7'd2) ? job_q.year - 14'd1 : job_q.year;
  assign mp   = (job_q.month > 7'd2) ? 4'(job_q.month - 7'd3) : 4'(job_q.month + 7'd9);
  assign p100 = {2'b00, ya[13:4], 2'b00} == '0 ? '0 : 24'(ya[13:2]) * 24'(RECIP25);
  assign p400 = 24'(ya[13:4]) * 24'(RECIP25);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_SPLIT;
      B_SPLIT: state_d = B_DAYS;
      B_DAYS:  state_d = B_MUL;
      B_MUL:   state_d = B_EMIT;
      B_EMIT:  if (!out_vld_q || !out_stall_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE:  pop_o    = !empty_i;
      B_EMIT:  load_out = !out_vld_q || !out_stall_i;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == B_SPLIT) begin
      ya_q   <= ya;
      doy_q  <= doy_of(mp);
      q100_q <= p100[23:16];
      q400_q <= p400[23:16];
      y365_q <= 22'(ya) * 22'd365;
      hsec_q <= 19'(job_q.hour) * 19'(SEC_PER_HR);
      msec_q <= 13'(job_q.minute) * 13'(SEC_PER_MIN);
    end
    if (state_q == B_DAYS) begin
      days_q <= 24'(y365_q) + 24'(ya_q[13:2]) + 24'(q400_q) + 24'(doy_q) + 24'(job_q.day)
                - 24'(q100_q) - EPOCH_DAYS1;
      hms_q  <= 20'(hsec_q) + 20'(msec_q) + 20'(job_q.second);
    end
    if (state_q == B_MUL) begin
      prod_q <= 41'(days_q) * 41'(SEC_PER_DAY);
    end
    if (load_out) begin
      out_q.ok      <= job_q.ok;
      out_q.seconds <= job_q.ok ? prod_q[37:0] + 38'(hms_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.ok |-> out_q.seconds == '0)
    else $error("error result carries nonzero seconds");

  a_pop_starts_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == B_SPLIT)
    else $error("job popped but sequencer did not start");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_EMIT && !out_stall_i |=> out_vld_q && state_q == B_IDLE)
    else $error("result not loaded from emit step");

endmodule
